/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define PCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next cycle.
`define PCE_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* sv/pce_pkg.sv */
`default_nettype none

package pce_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH        = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int ORIGIN_W    = 17;
  localparam int CANVAS_BITS = 16;

  // Decimal work is done on 17-bit values, wide enough for 9 * 10000.
  localparam int DEC_W     = 17;
  localparam int DEC_IDX_W = 3;
  localparam int COLOR_W   = 32;
  localparam int NIB_IDX_W = 3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  localparam logic [NIB_IDX_W-1:0] NIB_LAST_RGB  = 3'd5;
  localparam logic [NIB_IDX_W-1:0] NIB_LAST_RGBA = 3'd7;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_CANVAS_WIDTH  = 3'd2,
    REG_CANVAS_HEIGHT = 3'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_P,
    BK_X,
    BK_SP_X,
    BK_XDIG,
    BK_SP_Y,
    BK_YDIG,
    BK_SP_C,
    BK_HEX,
    BK_NL
  } back_state_t;

  // Per-pixel job fields that do not depend on the coordinate width.
  typedef struct packed {
    logic [DEC_IDX_W-1:0] x_top;
    logic [DEC_IDX_W-1:0] y_top;
    logic [COLOR_W-1:0]   color;
    logic                 has_alpha;
  } job_info_t;

  typedef struct packed {
    logic [3:0]       digit;
    logic [DEC_W-1:0] rem;
  } dec_step_t;

  function automatic logic [DEC_W-1:0] pow10(logic [DEC_IDX_W-1:0] k);
    logic [DEC_W-1:0] p;
    unique case (k)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

  // Index of the most significant decimal digit of v.
  function automatic logic [DEC_IDX_W-1:0] dec_top(logic [DEC_W-1:0] v);
    logic [DEC_IDX_W-1:0] t;
    if (v >= 17'd10000)     t = 3'd4;
    else if (v >= 17'd1000) t = 3'd3;
    else if (v >= 17'd100)  t = 3'd2;
    else if (v >= 17'd10)   t = 3'd1;
    else                    t = 3'd0;
    return t;
  endfunction

  // Digit at weight 10^k and what remains once it is taken off.
  function automatic dec_step_t dec_digit(logic [DEC_W-1:0] v, logic [DEC_IDX_W-1:0] k);
    dec_step_t  s;
    logic [20:0] w;
    s.digit = 4'd0;
    s.rem   = v;
    for (int i = 1; i <= 9; i++) begin
      w = 21'(i) * {4'b0000, pow10(k)};
      if ({4'b0000, v} >= w) begin
        s.digit = 4'(i);
        s.rem   = v - w[DEC_W-1:0];
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/pce_front.sv */
`default_nettype none

module pce_front import pce_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [15:0]            column,
  input  wire logic [15:0]            row_index,
  input  wire logic [7:0]             red,
  input  wire logic [7:0]             green,
  input  wire logic [7:0]             blue,
  input  wire logic [7:0]             alpha,
  input  wire logic                   q_full,
  output logic                        push,
  output logic [COORD_BITS-1:0]       job_x,
  output logic [COORD_BITS-1:0]       job_y,
  output job_info_t                   job_info
);

  logic [ORIGIN_W-1:0]    origin_x;
  logic [ORIGIN_W-1:0]    origin_y;
  logic [CANVAS_BITS-1:0] canvas_width;
  logic [CANVAS_BITS-1:0] canvas_height;

  logic [17:0] sx;
  logic [17:0] sy;
  logic        x_ok;
  logic        y_ok;
  logic        keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      canvas_width  <= 16'hFFFF;
      canvas_height <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      origin_x      <= cfg_data;
        REG_ORIGIN_Y:      origin_y      <= cfg_data;
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[CANVAS_BITS-1:0];
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data[CANVAS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Canvas position: unsigned image coordinate plus sign-extended origin.
  assign sx = {2'b00, column}    + {origin_x[ORIGIN_W-1], origin_x};
  assign sy = {2'b00, row_index} + {origin_y[ORIGIN_W-1], origin_y};

  assign x_ok = !sx[17] && (sx[16:0] < {1'b0, canvas_width})
                && ((sx[16:0] >> COORD_BITS) == 17'd0);
  assign y_ok = !sy[17] && (sy[16:0] < {1'b0, canvas_height})
                && ((sy[16:0] >> COORD_BITS) == 17'd0);
  assign keep = (alpha != 8'd0) && x_ok && y_ok;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full && keep;

  assign job_x              = sx[COORD_BITS-1:0];
  assign job_y              = sy[COORD_BITS-1:0];
  assign job_info.x_top     = dec_top(sx[DEC_W-1:0]);
  assign job_info.y_top     = dec_top(sy[DEC_W-1:0]);
  assign job_info.color     = {red, green, blue, alpha};
  assign job_info.has_alpha = (alpha != ALPHA_OPAQUE);

endmodule

`default_nettype wire

/* sv/pce_queue.sv */
`default_nettype none
`include "assert_macros.svh"

module pce_queue import pce_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `PCE_ASSERT(a_queue_no_overflow, !(push && full && !pop), "job queue written while full")
  `PCE_ASSERT(a_queue_no_underflow, !(pop && !not_empty), "job queue read while empty")

endmodule

`default_nettype wire

/* sv/pce_back.sv */
`default_nettype none
`include "assert_macros.svh"

module pce_back import pce_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire logic [COORD_BITS-1:0] q_x,
  input  wire logic [COORD_BITS-1:0] q_y,
  input  wire job_info_t             q_info,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       last
);

  back_state_t state, state_next;

  logic [COORD_BITS-1:0] x_rem, x_rem_next;
  logic [COORD_BITS-1:0] y_rem, y_rem_next;
  logic [DEC_IDX_W-1:0]  x_k, x_k_next;
  logic [DEC_IDX_W-1:0]  y_k, y_k_next;
  logic [COLOR_W-1:0]    color, color_next;
  logic                  has_alpha, has_alpha_next;
  logic [NIB_IDX_W-1:0]  nib, nib_next;
  logic                  out_valid_next;

  logic                  advance;
  logic                  emit;
  logic                  load;
  logic [7:0]            byte_val;
  logic                  last_val;
  logic                  on_y;
  logic [DEC_W-1:0]      dec_in;
  dec_step_t             dstep;

  assign advance = !out_valid || !out_stall;

  // One shared digit unit serves both coordinates.
  assign on_y   = (state == BK_YDIG);
  assign dec_in = {{(DEC_W - COORD_BITS){1'b0}}, (on_y ? y_rem : x_rem)};
  assign dstep  = dec_digit(dec_in, on_y ? y_k : x_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    x_rem     <= x_rem_next;
    y_rem     <= y_rem_next;
    x_k       <= x_k_next;
    y_k       <= y_k_next;
    color     <= color_next;
    has_alpha <= has_alpha_next;
    nib       <= nib_next;
    if (advance && emit) begin
      out_byte <= byte_val;
      last     <= last_val;
    end
  end

  always_comb begin
    state_next     = state;
    x_rem_next     = x_rem;
    y_rem_next     = y_rem;
    x_k_next       = x_k;
    y_k_next       = y_k;
    color_next     = color;
    has_alpha_next = has_alpha;
    nib_next       = nib;
    emit           = 1'b0;
    load           = 1'b0;
    byte_val       = CH_SPACE;
    last_val       = 1'b0;

    unique case (state)
      BK_IDLE: begin
        load = q_valid;
      end
      BK_P: begin
        if (advance) begin
          emit       = 1'b1;
          byte_val   = CH_P;
          state_next = BK_X;
        end
      end
      BK_X: begin
        if (advance) begin
          emit       = 1'b1;
          byte_val   = CH_X;
          state_next = BK_SP_X;
        end
      end
      BK_SP_X: begin
        if (advance) begin
          emit       = 1'b1;
          state_next = BK_XDIG;
        end
      end
      BK_XDIG: begin
        if (advance) begin
          emit       = 1'b1;
          byte_val   = CH_ZERO + {4'b0000, dstep.digit};
          x_rem_next = dstep.rem[COORD_BITS-1:0];
          if (x_k == '0) begin
            state_next = BK_SP_Y;
          end else begin
            x_k_next = x_k - 1'b1;
          end
        end
      end
      BK_SP_Y: begin
        if (advance) begin
          emit       = 1'b1;
          state_next = BK_YDIG;
        end
      end
      BK_YDIG: begin
        if (advance) begin
          emit       = 1'b1;
          byte_val   = CH_ZERO + {4'b0000, dstep.digit};
          y_rem_next = dstep.rem[COORD_BITS-1:0];
          if (y_k == '0) begin
            state_next = BK_SP_C;
          end else begin
            y_k_next = y_k - 1'b1;
          end
        end
      end
      BK_SP_C: begin
        if (advance) begin
          emit       = 1'b1;
          state_next = BK_HEX;
        end
      end
      BK_HEX: begin
        if (advance) begin
          emit       = 1'b1;
          byte_val   = HEX_DIGITS[color[COLOR_W-1 -: 4]];
          color_next = color << 4;
          nib_next   = nib + 1'b1;
          if (nib == (has_alpha ? NIB_LAST_RGBA : NIB_LAST_RGB)) begin
            state_next = BK_NL;
          end
        end
      end
      BK_NL: begin
        if (advance) begin
          emit       = 1'b1;
          byte_val   = CH_NL;
          last_val   = 1'b1;
          load       = q_valid;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    if (load) begin
      x_rem_next     = q_x;
      y_rem_next     = q_y;
      x_k_next       = q_info.x_top;
      y_k_next       = q_info.y_top;
      color_next     = q_info.color;
      has_alpha_next = q_info.has_alpha;
      nib_next       = '0;
      state_next     = BK_P;
    end

    pop            = load;
    out_valid_next = advance ? emit : out_valid;
  end

  `PCE_ASSERT(a_last_on_newline, !(out_valid && last) || (out_byte == CH_NL),
              "last flag on a byte other than newline")
  `PCE_ASSERT_NEXT(a_load_starts_command, load, state == BK_P,
                   "loaded job did not start with the command letter")

endmodule

`default_nettype wire

/* sv/pixel_command_encoder.sv */
// Path: a kept pixel goes through the job queue and the byte sequencer into out_byte.
// Throughput: one byte per cycle while out_stall is low, 14 to 24 bytes per kept pixel;
//   the byte sequencer sets the rate, and a dropped pixel never enters the job queue.
// Reset (rst, synchronous): origin 0/0, canvas 65535 x 65535, job queue empty,
//   sequencer idle and no output pending.
`default_nettype none

module pixel_command_encoder import pce_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,

  // Configuration writes, always ready.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  // Pixel requests.
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [15:0]            column,
  input  wire logic [15:0]            row_index,
  input  wire logic [7:0]             red,
  input  wire logic [7:0]             green,
  input  wire logic [7:0]             blue,
  input  wire logic [7:0]             alpha,

  // Command text, one ASCII byte per transfer.
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [7:0]                  out_byte,
  output logic                        last
);

  // Queue entry: canvas x, canvas y, then top digit indices and colour.
  localparam int JOB_W = 2 * COORD_BITS + $bits(job_info_t);

  logic                  q_full;
  logic                  q_not_empty;
  logic                  push;
  logic                  pop;
  logic [COORD_BITS-1:0] job_x;
  logic [COORD_BITS-1:0] job_y;
  job_info_t             job_info;
  logic [JOB_W-1:0]      q_rd_data;
  logic [COORD_BITS-1:0] q_x;
  logic [COORD_BITS-1:0] q_y;
  job_info_t             q_info;

  // Front-end configuration: users must write it only while idle; no check is made.
  assign cfg_ready = 1'b1;

  // Front: add the origin, drop transparent or off-canvas pixels, find the top digits.
  pce_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .column    (column),
    .row_index (row_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .q_full    (q_full),
    .push      (push),
    .job_x     (job_x),
    .job_y     (job_y),
    .job_info  (job_info)
  );

  // Short job queue: hold kept pixels while the back end spells out earlier ones.
  pce_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   ({job_x, job_y, job_info}),
    .pop       (pop),
    .rd_data   (q_rd_data),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign q_x    = q_rd_data[JOB_W-1 -: COORD_BITS];
  assign q_y    = q_rd_data[JOB_W-COORD_BITS-1 -: COORD_BITS];
  assign q_info = q_rd_data[$bits(job_info_t)-1:0];

  // Back: emit "PX x y RRGGBB[AA]\n" a byte at a time into the output register.
  pce_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_info    (q_info),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

`default_nettype wire

/* bench/tb.sv */
`default_nettype none

module tb;
  import pce_pkg::*;

  // Index that maps to no register; a write to it must leave the layout alone.
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd6;

  // Cycles to let pass after the last due byte, so that a dropped pixel still
  // in flight has left the pipe before the layout changes.
  localparam int SETTLE_CYCLES = 8;

  // Largest canvas position for a given number of decimal digits.
  localparam int DIGIT_SPAN [5] = '{9, 99, 999, 9999, 65535};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cmd_char_t;

  // How a row of the directed plan is handled: a register write, a pixel
  // whose command text is typed in, a pixel that must vanish, or a pixel
  // whose text comes from the encoder model below.
  typedef enum {ROW_CFG, ROW_TEXT, ROW_DROP, ROW_MODEL} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]    data;
    logic [15:0]              col;
    logic [15:0]              row;
    logic [7:0]               r;
    logic [7:0]               g;
    logic [7:0]               b;
    logic [7:0]               a;
    string                    text;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [15:0]            column;
  logic [15:0]            row_index;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic [7:0]             alpha;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [7:0]             out_byte;
  logic                   last;

  // Layout as the encoder should currently see it.
  logic signed [ORIGIN_W-1:0] org_x;
  logic signed [ORIGIN_W-1:0] org_y;
  logic [CANVAS_BITS-1:0]     canvas_cols;
  logic [CANVAS_BITS-1:0]     canvas_rows;

  cmd_char_t text_due [$];
  plan_row_t plan [$];
  int        err_count = 0;
  int        send_idle_pct;
  int        recv_stall_pct;

  pixel_command_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .column    (column),
    .row_index (row_index),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the encoder hangs or loses bytes.
  initial begin
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? 8'(8'h30 + nib) : 8'(8'h41 + nib - 4'd10);
  endfunction

  function automatic string hex_pair(logic [7:0] v);
    return $sformatf("%c%c", hex_char(v[7:4]), hex_char(v[3:0]));
  endfunction

  // Append one byte to the list of bytes the encoder owes.
  function automatic void due_char(logic [7:0] c, logic l);
    cmd_char_t item;
    item.ch   = c;
    item.last = l;
    text_due.insert(text_due.size(), item);
  endfunction

  // Queue a command line; the closing newline is appended here with last set.
  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) due_char(s[i], 1'b0);
    due_char(CH_NL, 1'b1);
  endfunction

  // Expected text for one pixel under the current layout. Nothing is queued
  // when the pixel is transparent or lands off the canvas.
  function automatic void encode_pixel(logic [15:0] col, logic [15:0] row,
                                       logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b, logic [7:0] a);
    int    sx;
    int    sy;
    string s;
    sx = int'(org_x) + int'({16'b0, col});
    sy = int'(org_y) + int'({16'b0, row});
    if (a == 8'd0) return;
    if (sx < 0 || sy < 0) return;
    if (sx >= int'({16'b0, canvas_cols}) || sy >= int'({16'b0, canvas_rows})) return;
    // Positions past the coordinate width cannot be written at all.
    if (sx >= (1 << COORD_BITS_DEFAULT) || sy >= (1 << COORD_BITS_DEFAULT)) return;
    s = {"PX ", $sformatf("%0d", sx), " ", $sformatf("%0d", sy), " ",
         hex_pair(r), hex_pair(g), hex_pair(b)};
    if (a != 8'hFF) s = {s, hex_pair(a)};
    queue_text(s);
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ORIGIN_X:      org_x = data;
      REG_ORIGIN_Y:      org_y = data;
      REG_CANVAS_WIDTH:  canvas_cols = data[CANVAS_BITS-1:0];
      REG_CANVAS_HEIGHT: canvas_rows = data[CANVAS_BITS-1:0];
      default: ;  // unknown index: drop the write
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Plan rows
  // ---------------------------------------------------------------------------

  function automatic void add_row(plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  function automatic plan_row_t cfg_step(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    plan_row_t p;
    p.kind = ROW_CFG;
    p.idx  = idx;
    p.data = data;
    p.col  = '0;
    p.row  = '0;
    p.r    = '0;
    p.g    = '0;
    p.b    = '0;
    p.a    = '0;
    p.text = "";
    return p;
  endfunction

  function automatic plan_row_t pixel_step(row_kind_t kind, logic [15:0] col, logic [15:0] row,
                                           logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a, string text);
    plan_row_t p;
    p.kind = kind;
    p.idx  = '0;
    p.data = '0;
    p.col  = col;
    p.row  = row;
    p.r    = r;
    p.g    = g;
    p.b    = b;
    p.a    = a;
    p.text = text;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers; every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Present one pixel request and hold it until the encoder takes it. The
  // valid is left high on return: the next caller either reuses it, drops it
  // for a gap, or lowers it when the burst ends.
  task automatic send_pixel(input row_kind_t kind, input logic [15:0] col,
                            input logic [15:0] row, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b,
                            input logic [7:0] a, input string text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    column    <= col;
    row_index <= row;
    red       <= r;
    green     <= g;
    blue      <= b;
    alpha     <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Accepted on this edge: log what the encoder owes for it.
    case (kind)
      ROW_TEXT:  queue_text(text);
      ROW_MODEL: encode_pixel(col, row, r, g, b, a);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stop requesting, wait for every due byte, then let a dropped pixel still
  // in flight drain out.
  task automatic finish_burst();
    in_valid <= 1'b0;
    while (text_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Draw a fresh layout. Style 0 keeps the canvas wide and the origin near
  // zero, style 1 roams over most of the range, style 2 uses a tiny canvas so
  // that edges and drops come up often.
  task automatic pick_layout(input int style);
    int ox;
    int oy;
    int cw;
    int ch;
    case (style)
      0: begin
        ox = int'($urandom_range(4000)) - 2000;
        oy = int'($urandom_range(4000)) - 2000;
        cw = ($urandom_range(1) == 0) ? 65535 : int'($urandom_range(65535, 30000));
        ch = ($urandom_range(1) == 0) ? 65535 : int'($urandom_range(65535, 30000));
      end
      1: begin
        ox = int'($urandom_range(60000)) - 30000;
        oy = int'($urandom_range(60000)) - 30000;
        cw = int'($urandom_range(65535, 1));
        ch = int'($urandom_range(65535, 1));
      end
      default: begin
        ox = int'($urandom_range(600)) - 300;
        oy = int'($urandom_range(600)) - 300;
        cw = int'($urandom_range(400, 1));
        ch = int'($urandom_range(400, 1));
      end
    endcase
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_CANVAS_WIDTH, CFG_DATA_W'(cw));
    write_reg(REG_CANVAS_HEIGHT, CFG_DATA_W'(ch));
  endtask

  // Mostly aim at the canvas, with a digit count drawn at random so that
  // every coordinate length shows up; the rest are raw coordinates.
  task automatic random_pixel();
    int          sx;
    int          sy;
    int          ci;
    int          ri;
    int          span;
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  a;
    col = 16'($urandom);
    row = 16'($urandom);
    if ($urandom_range(99) < 80 && canvas_cols != 0 && canvas_rows != 0) begin
      span = DIGIT_SPAN[$urandom_range(4)];
      sx = int'($urandom_range((int'(canvas_cols) - 1 < span) ? int'(canvas_cols) - 1 : span));
      span = DIGIT_SPAN[$urandom_range(4)];
      sy = int'($urandom_range((int'(canvas_rows) - 1 < span) ? int'(canvas_rows) - 1 : span));
      ci = sx - int'(org_x);
      ri = sy - int'(org_y);
      if (ci >= 0 && ci <= 65535) col = ci[15:0];
      if (ri >= 0 && ri <= 65535) row = ri[15:0];
    end
    case ($urandom_range(99)) inside
      [0:7]:   a = 8'd0;
      [8:34]:  a = 8'hFF;
      default: a = 8'($urandom_range(255));
    endcase
    send_pixel(ROW_MODEL, col, row, 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)), a, "");
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Stall the byte stream at random; the rate is set per phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compare every accepted byte with the oldest one due.
  always @(posedge clk) begin : check_bytes
    cmd_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (text_due.size() == 0) begin
        $error("out_byte: expected none pending, actual %h (last %b)", out_byte, last);
        err_count++;
      end else begin
        want = text_due.pop_front();
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %h, actual %h", want.ch, out_byte);
          err_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, last);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    column         = '0;
    row_index      = '0;
    red            = '0;
    green          = '0;
    blue           = '0;
    alpha          = '0;
    org_x          = '0;
    org_y          = '0;
    canvas_cols    = 16'hFFFF;
    canvas_rows    = 16'hFFFF;
    send_idle_pct  = 17;
    recv_stall_pct = 71;

    // Reset layout: origin 0/0, canvas 65535 x 65535. Text typed in where it
    // is plain to see.
    add_row(pixel_step(ROW_TEXT, 16'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'hFF,
                       "PX 0 0 000000"));
    add_row(pixel_step(ROW_TEXT, 16'd65534, 16'd65534, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
                       "PX 65534 65534 FFFFFFFE"));
    // Just past the right and bottom edges of the canvas.
    add_row(pixel_step(ROW_DROP, 16'd65535, 16'd0, 8'h10, 8'h20, 8'h30, 8'hFF, ""));
    add_row(pixel_step(ROW_DROP, 16'd0, 16'd65535, 8'h10, 8'h20, 8'h30, 8'hFF, ""));
    // Transparent pixel.
    add_row(pixel_step(ROW_DROP, 16'd12, 16'd345, 8'h12, 8'h34, 8'h56, 8'h00, ""));
    add_row(pixel_step(ROW_TEXT, 16'd9, 16'd10, 8'hAB, 8'hCD, 8'hEF, 8'h01,
                       "PX 9 10 ABCDEF01"));
    add_row(pixel_step(ROW_TEXT, 16'd99, 16'd100, 8'h01, 8'h23, 8'h45, 8'hFF,
                       "PX 99 100 012345"));
    add_row(pixel_step(ROW_TEXT, 16'd999, 16'd1000, 8'h67, 8'h89, 8'h5A, 8'h80,
                       "PX 999 1000 67895A80"));
    add_row(pixel_step(ROW_TEXT, 16'd9999, 16'd10000, 8'hA5, 8'h5A, 8'hC3, 8'h7F,
                       "PX 9999 10000 A55AC37F"));
    add_row(pixel_step(ROW_TEXT, 16'd10000, 16'd9999, 8'h3C, 8'hF0, 8'h0F, 8'hFF,
                       "PX 10000 9999 3CF00F"));
    // A write to an unused index must leave the reset layout in place.
    add_row(cfg_step(REG_NONE, 17'h1FFFF));
    add_row(pixel_step(ROW_TEXT, 16'd7, 16'd7, 8'h80, 8'h80, 8'h80, 8'hFF,
                       "PX 7 7 808080"));
    // Most negative origin: every x lands left of the canvas.
    add_row(cfg_step(REG_ORIGIN_X, 17'h10000));
    add_row(cfg_step(REG_ORIGIN_Y, 17'h1FFFF));
    add_row(pixel_step(ROW_MODEL, 16'd65535, 16'd1, 8'h11, 8'h22, 8'h33, 8'hFF, ""));
    // Origin -1/0: column 0 falls off, column 1 lands on x 0.
    add_row(cfg_step(REG_ORIGIN_X, 17'h1FFFF));
    add_row(cfg_step(REG_ORIGIN_Y, 17'h00000));
    add_row(pixel_step(ROW_MODEL, 16'd0, 16'd5, 8'h44, 8'h55, 8'h66, 8'hFF, ""));
    add_row(pixel_step(ROW_MODEL, 16'd1, 16'd5, 8'h44, 8'h55, 8'h66, 8'hFF, ""));
    add_row(cfg_step(REG_ORIGIN_Y, 17'h1FFFF));
    add_row(pixel_step(ROW_MODEL, 16'd5, 16'd0, 8'h77, 8'h88, 8'h99, 8'h40, ""));
    // Largest positive origin: on the canvas edge, then past the coordinate width.
    add_row(cfg_step(REG_ORIGIN_X, 17'h0FFFF));
    add_row(cfg_step(REG_ORIGIN_Y, 17'h00000));
    add_row(pixel_step(ROW_MODEL, 16'd0, 16'd0, 8'hAA, 8'hBB, 8'hCC, 8'hFF, ""));
    add_row(pixel_step(ROW_MODEL, 16'd65535, 16'd65535, 8'hAA, 8'hBB, 8'hCC, 8'hFF, ""));
    // Zero-size canvas drops everything; a 1 x 1 canvas keeps only 0/0.
    add_row(cfg_step(REG_ORIGIN_X, 17'h00000));
    add_row(cfg_step(REG_CANVAS_WIDTH, 17'h00000));
    add_row(pixel_step(ROW_MODEL, 16'd0, 16'd0, 8'h01, 8'h02, 8'h03, 8'hFF, ""));
    add_row(cfg_step(REG_CANVAS_WIDTH, 17'h00001));
    add_row(cfg_step(REG_CANVAS_HEIGHT, 17'h00000));
    add_row(pixel_step(ROW_MODEL, 16'd0, 16'd0, 8'h01, 8'h02, 8'h03, 8'hFF, ""));
    add_row(cfg_step(REG_CANVAS_HEIGHT, 17'h00001));
    add_row(pixel_step(ROW_MODEL, 16'd0, 16'd0, 8'hFE, 8'hDC, 8'hBA, 8'hFF, ""));
    add_row(pixel_step(ROW_MODEL, 16'd1, 16'd0, 8'hFE, 8'hDC, 8'hBA, 8'hFF, ""));
    add_row(pixel_step(ROW_MODEL, 16'd0, 16'd1, 8'hFE, 8'hDC, 8'hBA, 8'hFF, ""));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed plan; drain before each register write.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        finish_burst();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].kind, plan[i].col, plan[i].row, plan[i].r, plan[i].g,
                   plan[i].b, plan[i].a, plan[i].text);
      end
    end

    // Random traffic: three idling profiles, two layouts each.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 17;
          recv_stall_pct = 71;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 17;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int half = 0; half < 2; half++) begin
        finish_burst();
        pick_layout((2 * phase + half) % 3);
        repeat (35) random_pixel();
      end
    end

    finish_burst();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
